FILE: sv/srsg_pkg.sv
// Shared types and constants of the stepper ramp step generator.
package srsg_pkg;

    // Field widths of the stream words
    localparam int TGT_W    = 16;
    localparam int SPEED_W  = 16;
    localparam int PER_US_W = 20;
    localparam int DEG_W    = 16;
    localparam int M_DATA_W = 56;

    // Serial divider: dividend and divisor widths, step counter width
    localparam int DIV_W     = 27;
    localparam int DEN_W     = 24;
    localparam int DIV_CNT_W = 5;

    localparam int US_PER_SEC  = 1000000;
    localparam int DEG_PER_REV = 360;
    localparam int SPEED_LIMIT = 32767;

    // Register index codes (byte address 4*index)
    localparam logic [2:0] REG_ACCEL_LIMIT  = 3'd0;
    localparam logic [2:0] REG_FWD_POLARITY = 3'd1;
    localparam logic [2:0] REG_MAX_SPEED    = 3'd2;
    localparam logic [2:0] REG_STEPS_REV    = 3'd3;
    localparam logic [2:0] REG_MICROSTEP    = 3'd4;

    // Result word, step_pulse in bit 0
    typedef struct packed {
        logic [DEG_W-1:0]    deg;
        logic [PER_US_W-1:0] period;
        logic [SPEED_W-1:0]  speed;
        logic                dir;
        logic                pulse;
    } out_word_t;

endpackage

FILE: sv/stepper_ramp_step_generator.sv
// Stepper step-rate generator with acceleration limit, APB config and stream ports.
//
// Each input word is either a 1 us tick (s_axis_tuser = 0) or a speed command
// (s_axis_tuser = 1, target in deg/s in s_axis_tdata). A command clips the target
// to +/-max_speed_deg, converts it to steps/s (truncated, saturated to +/-32767),
// moves the ramped speed toward it by at most accel_limit, updates the direction
// line (held at zero speed) and recomputes the step period 1000000 / (|speed| *
// microstep_factor). A tick runs the step countdown and emits one step pulse every
// period + 1 ticks. Every input word produces exactly one result word carrying the
// pulse, direction, speed, period and speed in deg/s. All three quotients share one
// restoring divider that retires one quotient bit per cycle. A word is taken only in
// the idle state, once the last is through; a tick runs the degree division, a command
// also the target and period divisions, the latter skipped when its divisor is zero.
// The result sits in an output register, so the next word is accepted while it waits.
// The user must write the configuration registers only while the block is idle; the block does not enforce this.
module stepper_ramp_step_generator #(
    parameter int PERIOD_BITS = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] target_speed_deg
    input  logic        s_axis_tuser,   // [0] mode: 0 tick, 1 command
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] step_pulse, [1] direction_level, [17:2] speed_steps,
    // [37:18] period_us, [53:38] current_speed_deg, [55:54] zero
    output logic [55:0] m_axis_tdata,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Sequencer codes
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_CLIP    = 4'd1;
    localparam logic [3:0] ST_TGT_MUL = 4'd2;
    localparam logic [3:0] ST_TGT_DIV = 4'd3;
    localparam logic [3:0] ST_RAMP    = 4'd4;
    localparam logic [3:0] ST_PER_MUL = 4'd5;
    localparam logic [3:0] ST_PER_DIV = 4'd6;
    localparam logic [3:0] ST_PER_SAT = 4'd7;
    localparam logic [3:0] ST_DEG_MUL = 4'd8;
    localparam logic [3:0] ST_DEG_DIV = 4'd9;
    localparam logic [3:0] ST_OUT     = 4'd10;

    localparam int QX_W = PERIOD_BITS + srsg_pkg::DIV_W;
    localparam logic [QX_W-1:0] PMASK_EXT = QX_W'((64'd1 << PERIOD_BITS) - 64'd1);

    // Configuration registers
    logic [10:0] accel_reg,  accel_next;
    logic        pol_reg,    pol_next;
    logic [14:0] max_deg_reg, max_deg_next;
    logic [11:0] spr_reg,    spr_next;
    logic [8:0]  ustep_reg,  ustep_next;

    // Control and motion state
    logic [3:0]               state_reg, state_next;
    logic signed [15:0]       ramped_reg, ramped_next;
    logic [PERIOD_BITS-1:0]   period_reg, period_next;
    logic [PERIOD_BITS-1:0]   countdown_reg, countdown_next;
    logic                     dir_reg, dir_next;
    logic                     pulse_reg, pulse_next;
    logic                     out_valid_reg, out_valid_next;
    srsg_pkg::out_word_t      out_reg, out_next;

    // Command working registers
    logic signed [15:0] tgt_reg, tgt_next;
    logic [14:0]        mag_reg, mag_next;
    logic               neg_reg, neg_next;

    // Serial divider
    logic [srsg_pkg::DIV_W-1:0]     div_num_reg, div_num_next;
    logic [srsg_pkg::DEN_W-1:0]     div_den_reg, div_den_next;
    logic [srsg_pkg::DEN_W:0]       div_rem_reg, div_rem_next;
    logic [srsg_pkg::DIV_W-1:0]     div_quo_reg, div_quo_next;
    logic [srsg_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    logic                     apb_wr;
    logic                     s_accept;
    logic signed [15:0]       lim_s, clip_val;
    logic [15:0]              clip_abs;
    logic [srsg_pkg::DIV_W-1:0] tgt_prod;
    logic [srsg_pkg::DEN_W:0] rem_sh;
    logic [srsg_pkg::DEN_W+1:0] trial;
    logic                     div_fits;
    logic                     div_run;
    logic [14:0]              q_sat;
    logic signed [15:0]       desired;
    logic signed [16:0]       diff, acc_s;
    logic signed [15:0]       ramp_val;
    logic [15:0]              ramp_abs;
    logic [14:0]              rmag;
    logic [srsg_pkg::DEN_W-1:0] per_prod, deg_num;
    logic [QX_W-1:0]          quo_ext;
    logic [PERIOD_BITS-1:0]   period_sat;
    logic [PERIOD_BITS+19:0]  per_ext;
    logic signed [15:0]       deg_val;

    assign pready        = 1'b1;
    assign apb_wr        = psel & penable & pwrite;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_reg};

    // Register read-back
    always_comb begin
        case (paddr[4:2])
            srsg_pkg::REG_ACCEL_LIMIT:  prdata = {21'd0, accel_reg};
            srsg_pkg::REG_FWD_POLARITY: prdata = {31'd0, pol_reg};
            srsg_pkg::REG_MAX_SPEED:    prdata = {17'd0, max_deg_reg};
            srsg_pkg::REG_STEPS_REV:    prdata = {20'd0, spr_reg};
            srsg_pkg::REG_MICROSTEP:    prdata = {23'd0, ustep_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // Datapath pieces
    always_comb begin
        // clip the command to +/-max_speed_deg
        lim_s = $signed({1'b0, max_deg_reg});
        if (tgt_reg < -lim_s) begin
            clip_val = -lim_s;
        end else if (tgt_reg > lim_s) begin
            clip_val = lim_s;
        end else begin
            clip_val = tgt_reg;
        end
        clip_abs = clip_val[15] ? 16'(-clip_val) : 16'(clip_val);
        tgt_prod = srsg_pkg::DIV_W'(mag_reg) * srsg_pkg::DIV_W'(spr_reg);

        // one restoring division step
        rem_sh   = {div_rem_reg[srsg_pkg::DEN_W-1:0], div_num_reg[srsg_pkg::DIV_W-1]};
        trial    = {1'b0, rem_sh} - {2'b00, div_den_reg};
        div_fits = ~trial[srsg_pkg::DEN_W+1];

        // quotient saturated to the speed limit
        q_sat = (div_quo_reg > srsg_pkg::DIV_W'(srsg_pkg::SPEED_LIMIT)) ?
                15'(srsg_pkg::SPEED_LIMIT) : div_quo_reg[14:0];
        desired = neg_reg ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});

        // acceleration-limited ramp
        diff  = 17'(ramped_reg) - 17'(desired);
        acc_s = $signed({6'd0, accel_reg});
        if (diff > acc_s) begin
            ramp_val = 16'(17'(ramped_reg) - acc_s);
        end else if (diff < -acc_s) begin
            ramp_val = 16'(17'(ramped_reg) + acc_s);
        end else begin
            ramp_val = desired;
        end

        ramp_abs = ramped_reg[15] ? 16'(-ramped_reg) : 16'(ramped_reg);
        rmag     = ramp_abs[14:0];
        per_prod = srsg_pkg::DEN_W'(rmag) * srsg_pkg::DEN_W'(ustep_reg);
        deg_num  = srsg_pkg::DEN_W'(rmag) * srsg_pkg::DEN_W'(srsg_pkg::DEG_PER_REV);

        quo_ext    = QX_W'(div_quo_reg);
        period_sat = (quo_ext > PMASK_EXT) ? '1 : quo_ext[PERIOD_BITS-1:0];
        per_ext    = (PERIOD_BITS + 20)'(period_reg);

        if (spr_reg == 12'd0) begin
            deg_val = 16'sd0;
        end else if (ramped_reg[15]) begin
            deg_val = -$signed({1'b0, q_sat});
        end else begin
            deg_val = $signed({1'b0, q_sat});
        end
    end

    assign div_run = (state_reg == ST_TGT_DIV) || (state_reg == ST_PER_DIV) ||
                     (state_reg == ST_DEG_DIV);

    // Sequencer and next-state logic
    always_comb begin
        accel_next     = accel_reg;
        pol_next       = pol_reg;
        max_deg_next   = max_deg_reg;
        spr_next       = spr_reg;
        ustep_next     = ustep_reg;
        state_next     = state_reg;
        ramped_next    = ramped_reg;
        period_next    = period_reg;
        countdown_next = countdown_reg;
        dir_next       = dir_reg;
        pulse_next     = pulse_reg;
        out_valid_next = out_valid_reg & ~m_axis_tready;
        out_next       = out_reg;
        tgt_next       = tgt_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        div_num_next   = div_num_reg;
        div_den_next   = div_den_reg;
        div_rem_next   = div_rem_reg;
        div_quo_next   = div_quo_reg;
        div_cnt_next   = div_cnt_reg;

        if (apb_wr) begin
            case (paddr[4:2])
                srsg_pkg::REG_ACCEL_LIMIT:  accel_next   = pwdata[10:0];
                srsg_pkg::REG_FWD_POLARITY: pol_next     = pwdata[0];
                srsg_pkg::REG_MAX_SPEED:    max_deg_next = pwdata[14:0];
                srsg_pkg::REG_STEPS_REV:    spr_next     = pwdata[11:0];
                srsg_pkg::REG_MICROSTEP:    ustep_next   = pwdata[8:0];
                default: ;
            endcase
        end

        if (div_run) begin
            div_num_next = {div_num_reg[srsg_pkg::DIV_W-2:0], 1'b0};
            div_rem_next = div_fits ? trial[srsg_pkg::DEN_W:0] : rem_sh;
            div_quo_next = {div_quo_reg[srsg_pkg::DIV_W-2:0], div_fits};
            div_cnt_next = div_cnt_reg - 1'b1;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    pulse_next = 1'b0;
                    if (s_axis_tuser) begin
                        tgt_next   = $signed(s_axis_tdata);
                        state_next = ST_CLIP;
                    end else begin
                        if (countdown_reg == '0) begin
                            if (period_reg != '0) begin
                                pulse_next     = 1'b1;
                                countdown_next = period_reg;
                            end
                        end else begin
                            countdown_next = countdown_reg - 1'b1;
                        end
                        state_next = ST_DEG_MUL;
                    end
                end
            end
            ST_CLIP: begin
                mag_next   = clip_abs[14:0];
                neg_next   = clip_val[15];
                state_next = ST_TGT_MUL;
            end
            ST_TGT_MUL: begin
                div_num_next = tgt_prod;
                div_den_next = srsg_pkg::DEN_W'(srsg_pkg::DEG_PER_REV);
                div_rem_next = '0;
                div_quo_next = '0;
                div_cnt_next = srsg_pkg::DIV_CNT_W'(srsg_pkg::DIV_W);
                state_next   = ST_TGT_DIV;
            end
            ST_TGT_DIV: begin
                if (div_cnt_reg == srsg_pkg::DIV_CNT_W'(1)) begin
                    state_next = ST_RAMP;
                end
            end
            ST_RAMP: begin
                ramped_next = ramp_val;
                if (ramp_val > 16'sd0) begin
                    dir_next = pol_reg;
                end else if (ramp_val < 16'sd0) begin
                    dir_next = ~pol_reg;
                end
                state_next = ST_PER_MUL;
            end
            ST_PER_MUL: begin
                if (per_prod == '0) begin
                    period_next = '0;
                    state_next  = ST_DEG_MUL;
                end else begin
                    div_num_next = srsg_pkg::DIV_W'(srsg_pkg::US_PER_SEC);
                    div_den_next = per_prod;
                    div_rem_next = '0;
                    div_quo_next = '0;
                    div_cnt_next = srsg_pkg::DIV_CNT_W'(srsg_pkg::DIV_W);
                    state_next   = ST_PER_DIV;
                end
            end
            ST_PER_DIV: begin
                if (div_cnt_reg == srsg_pkg::DIV_CNT_W'(1)) begin
                    state_next = ST_PER_SAT;
                end
            end
            ST_PER_SAT: begin
                period_next = period_sat;
                state_next  = ST_DEG_MUL;
            end
            ST_DEG_MUL: begin
                div_num_next = srsg_pkg::DIV_W'(deg_num);
                div_den_next = srsg_pkg::DEN_W'(spr_reg);
                div_rem_next = '0;
                div_quo_next = '0;
                div_cnt_next = srsg_pkg::DIV_CNT_W'(srsg_pkg::DIV_W);
                state_next   = ST_DEG_DIV;
            end
            ST_DEG_DIV: begin
                if (div_cnt_reg == srsg_pkg::DIV_CNT_W'(1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // wait here only while the previous word is still unclaimed
                if (!out_valid_reg || m_axis_tready) begin
                    out_next.pulse  = pulse_reg;
                    out_next.dir    = dir_reg;
                    out_next.speed  = ramped_reg;
                    out_next.period = per_ext[19:0];
                    out_next.deg    = deg_val;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_reg     <= 11'd32;
            pol_reg       <= 1'b1;
            max_deg_reg   <= 15'd720;
            spr_reg       <= 12'd200;
            ustep_reg     <= 9'd16;
            state_reg     <= ST_IDLE;
            ramped_reg    <= '0;
            period_reg    <= '0;
            countdown_reg <= '0;
            dir_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            div_cnt_reg   <= '0;
        end else begin
            accel_reg     <= accel_next;
            pol_reg       <= pol_next;
            max_deg_reg   <= max_deg_next;
            spr_reg       <= spr_next;
            ustep_reg     <= ustep_next;
            state_reg     <= state_next;
            ramped_reg    <= ramped_next;
            period_reg    <= period_next;
            countdown_reg <= countdown_next;
            dir_reg       <= dir_next;
            out_valid_reg <= out_valid_next;
            div_cnt_reg   <= div_cnt_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        pulse_reg   <= pulse_next;
        out_reg     <= out_next;
        tgt_reg     <= tgt_next;
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        div_num_reg <= div_num_next;
        div_den_reg <= div_den_next;
        div_rem_reg <= div_rem_next;
        div_quo_reg <= div_quo_next;
    end

    // Checks
    a_pulse_has_period: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.pulse) |-> (out_reg.period != 20'd0))
        else $error("step pulse reported with a zero period");

    a_speed_symmetric: assert property (@(posedge aclk) disable iff (!aresetn)
        ramped_reg != 16'sh8000)
        else $error("ramped speed left the symmetric range");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg != ST_IDLE))
        else $error("accepted word did not start the sequencer");

    a_div_count_live: assert property (@(posedge aclk) disable iff (!aresetn)
        div_run |-> (div_cnt_reg != '0))
        else $error("divider running with an exhausted step count");

endmodule
